/* hw/rtl/nsis_pkg.sv */
// Shared constants and types for the nearest sorted index search block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nsis_pkg;

    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int CNT_W           = 13;
    localparam int IDX_W           = 12;
    localparam int VAL_W           = 32;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK0,
        ST_CHKN,
        ST_DBL,
        ST_BIN_ISS,
        ST_BIN_DAT,
        ST_FIX_R,
        ST_FIX_L,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/nearest_sorted_index_search_top.sv */
// Sorted table with nearest-index query: table RAM, search sequencer, result register.
// Depends on nsis_pkg.
// A load writes the table while the sequencer is idle. A query compares against the first
// entry, then the last, then runs doubling reads, binary steps and a neighbour compare;
// one query in flight, since input is taken only while the sequencer is idle.
// Reset clears the sequencer and result valid and sets entry_count to 1; table contents
// are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module nearest_sorted_index_search_top #(
    parameter int MAX_ENTRIES = nsis_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [nsis_pkg::CNT_W-1:0] cfg_wr_data,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [47:0]               s_tdata,  // entry_index[11:0], value[43:12]
    input  wire logic                      s_tuser,  // mode
    input  wire logic                      s_tlast,  // final_query
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [15:0]                    m_tdata,  // nearest_index[11:0]
    output logic                           m_tlast   // batch_end
);
    import nsis_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = AW + 2;
    localparam logic [31:0] MAX_W = 32'(MAX_ENTRIES);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]       count_reg;
    logic signed [VAL_W-1:0] mem [MAX_ENTRIES];
    logic signed [VAL_W-1:0] rdata_reg;
    logic signed [VAL_W-1:0] v_reg;
    logic signed [VAL_W-1:0] b_reg;
    logic                    last_reg;
    logic [CW-1:0]           lo_reg, hi_reg, first_reg, lastb_reg, mid_reg, r_reg;
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic                    out_last_reg;

    logic [CW-1:0]          rd_addr;
    logic [CW-1:0]          n_eff;
    logic [31:0]            cnt32;
    logic [IDX_W-1:0]       s_idx;
    logic signed [VAL_W-1:0] s_val;
    logic                   in_xfer;
    logic                   rd_lt_v;
    logic                   v_lt_rd;
    logic [CW-1:0]          hi2;
    logic                   hi2_lt_n;
    logic                   bin_go;
    logic [CW-1:0]          mid_calc;
    logic [CW-1:0]          r_clamp;
    logic signed [VAL_W+1:0] sum_pair;
    logic signed [VAL_W+1:0] v_dbl;
    logic                   step_down;
    logic                   done_fire;

    assign s_idx   = s_tdata[11:0];
    assign s_val   = s_tdata[43:12];
    assign in_xfer = s_tvalid && s_tready;

    assign cnt32 = 32'(count_reg);
    always_comb
    begin
        if (cnt32 == 32'd0)
            n_eff = CW'(1);
        else if (cnt32 > MAX_W)
            n_eff = CW'(MAX_ENTRIES);
        else
            n_eff = CW'(count_reg);
    end

    assign rd_lt_v   = rdata_reg < v_reg;
    assign v_lt_rd   = v_reg < rdata_reg;
    assign hi2       = hi_reg << 1;
    assign hi2_lt_n  = hi2 < n_eff;
    assign bin_go    = first_reg < lastb_reg;
    assign mid_calc  = first_reg + ((lastb_reg - first_reg) >> 1);
    assign r_clamp   = (first_reg >= n_eff) ? (n_eff - CW'(1)) : first_reg;
    assign sum_pair  = $signed({{2{rdata_reg[VAL_W-1]}}, rdata_reg})
                     + $signed({{2{b_reg[VAL_W-1]}}, b_reg});
    assign v_dbl     = $signed({v_reg[VAL_W-1], v_reg, 1'b0});
    assign step_down = v_dbl <= sum_pair;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && s_tuser == MODE_QUERY)
                    state_next = ST_CHK0;
            end
            ST_CHK0:
            begin
                if (v_lt_rd)
                    state_next = ST_DONE;
                else
                    state_next = ST_CHKN;
            end
            ST_CHKN:
            begin
                if (rd_lt_v)
                    state_next = ST_DONE;
                else if (n_eff > CW'(1))
                    state_next = ST_DBL;
                else
                    state_next = ST_BIN_ISS;
            end
            ST_DBL:
            begin
                if (!(rd_lt_v && hi2_lt_n))
                    state_next = ST_BIN_ISS;
            end
            ST_BIN_ISS:
            begin
                if (bin_go)
                    state_next = ST_BIN_DAT;
                else if (r_clamp != '0)
                    state_next = ST_FIX_R;
                else
                    state_next = ST_DONE;
            end
            ST_BIN_DAT: state_next = ST_BIN_ISS;
            ST_FIX_R:   state_next = ST_FIX_L;
            ST_FIX_L:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (done_fire)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs: read address and input ready
    always_comb
    begin
        rd_addr  = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_CHK0:    rd_addr  = n_eff - CW'(1);
            ST_CHKN:    rd_addr  = CW'(1);
            ST_DBL:     rd_addr  = hi2;
            ST_BIN_ISS:
            begin
                if (bin_go)
                    rd_addr = mid_calc;
                else
                    rd_addr = r_clamp;
            end
            ST_FIX_R:   rd_addr  = r_reg - CW'(1);
            default:    rd_addr  = '0;
        endcase
    end

    // table RAM
    always_ff @(posedge clk)
    begin
        if (in_xfer && s_tuser == MODE_LOAD && {20'd0, s_idx} < MAX_W)
            mem[AW'(s_idx)] <= s_val;
        rdata_reg <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
            if (done_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // search datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                v_reg    <= s_val;
                last_reg <= s_tlast;
            end
            ST_CHK0:
            begin
                r_reg <= '0;
            end
            ST_CHKN:
            begin
                r_reg     <= n_eff - CW'(1);
                lo_reg    <= '0;
                hi_reg    <= CW'(1);
                first_reg <= '0;
                lastb_reg <= n_eff;
            end
            ST_DBL:
            begin
                if (rd_lt_v)
                begin
                    lo_reg    <= hi_reg;
                    hi_reg    <= hi2;
                    first_reg <= hi_reg;
                    lastb_reg <= (n_eff <= hi2) ? n_eff : hi2 + CW'(1);
                end
                else
                begin
                    first_reg <= lo_reg;
                    lastb_reg <= (n_eff <= hi_reg) ? n_eff : hi_reg + CW'(1);
                end
            end
            ST_BIN_ISS:
            begin
                mid_reg <= mid_calc;
                r_reg   <= r_clamp;
            end
            ST_BIN_DAT:
            begin
                if (rd_lt_v)
                    first_reg <= mid_reg + CW'(1);
                else
                    lastb_reg <= mid_reg;
            end
            ST_FIX_R:
            begin
                b_reg <= rdata_reg;
            end
            ST_FIX_L:
            begin
                if (step_down)
                    r_reg <= r_reg - CW'(1);
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    out_idx_reg  <= IDX_W'(r_reg);
                    out_last_reg <= last_reg;
                end
            end
            default:
            begin
                r_reg <= r_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_idx_reg};
    assign m_tlast  = out_last_reg;

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == MODE_QUERY) |=> state_reg == ST_CHK0)
        else $error("query transfer did not start the search");

    a_bracket_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BIN_ISS) |-> first_reg <= lastb_reg)
        else $error("binary search bracket inverted");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BIN_DAT) |-> (mid_reg < lastb_reg && mid_reg >= first_reg))
        else $error("binary search midpoint outside bracket");

    a_dbl_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DBL) |-> hi_reg < n_eff)
        else $error("doubling read beyond entry count");

    a_fix_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX_R) |-> (r_reg != '0 && r_reg < n_eff))
        else $error("tie check on invalid index");

endmodule

`default_nettype wire
